[hdl/early_warning_vitals_triage_macros.svh]
// Assertion macros shared by the vitals triage RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef EARLY_WARNING_VITALS_TRIAGE_MACROS_SVH
`define EARLY_WARNING_VITALS_TRIAGE_MACROS_SVH
`ifndef ASSERT_OFF
`define EWVT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ewvt assertion failed");
`define EWVT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ewvt implication failed");
`else
`define EWVT_ASSERT(lbl, clk, rst, prop)
`define EWVT_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/ewvt_pkg.sv]
// Types, codes and thresholds for the vitals triage pipeline.
// Has no dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ewvt_pkg;

   typedef enum logic [1:0] {
      STATUS_ASSESSED = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_HELD     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      LEVEL_NORMAL   = 2'd0,
      LEVEL_ELEVATED = 2'd1,
      LEVEL_HIGH     = 2'd2,
      LEVEL_CRITICAL = 2'd3
   } level_type;

   localparam logic CSR_SHOCK_RMSSD_LIMIT  = 1'b0;
   localparam logic CSR_QUALITY_HOLD_LIMIT = 1'b1;

   localparam logic [12:0] SHOCK_RMSSD_RESET  = 13'd80;
   localparam logic [8:0]  QUALITY_HOLD_RESET = 9'd180;

   localparam logic [12:0] HR_Q4_VALID_MAX   = 13'd5599;
   localparam logic [10:0] SPO2_Q4_VALID_MAX = 11'd1600;
   localparam logic [12:0] RMSSD_AVAIL_MAX   = 13'd4999;
   localparam logic [6:0]  RR_DEFAULT        = 7'd14;

   localparam int ALERT_LOW_SPO2    = 0;
   localparam int ALERT_FAST_HEART  = 1;
   localparam int ALERT_SLOW_HEART  = 2;
   localparam int ALERT_FAST_BREATH = 3;
   localparam int ALERT_SLOW_BREATH = 4;
   localparam int ALERT_SHOCK       = 5;
   localparam int ALERT_NOISE       = 6;

   localparam logic [8:0] HR_BAND_LOW3  = 9'd40;
   localparam logic [8:0] HR_BAND_LOW1  = 9'd50;
   localparam logic [8:0] HR_BAND_NORM  = 9'd90;
   localparam logic [8:0] HR_BAND_HIGH1 = 9'd110;
   localparam logic [8:0] HR_BAND_HIGH2 = 9'd130;
   localparam logic [8:0] HR_CRISIS_HI  = 9'd150;
   localparam logic [8:0] HR_CRISIS_LO  = 9'd39;
   localparam logic [8:0] HR_SHOCK_MIN  = 9'd100;

   localparam logic [6:0] SP_BAND_NORM   = 7'd96;
   localparam logic [6:0] SP_BAND_MILD   = 7'd94;
   localparam logic [6:0] SP_BAND_MOD    = 7'd92;
   localparam logic [6:0] SP_HYPOXIA_MAX = 7'd91;
   localparam logic [6:0] SP_CRISIS_MAX  = 7'd85;
   localparam logic [6:0] SP_SHOCK_MAX   = 7'd94;

   localparam logic [6:0] RR_BAND_LOW3  = 7'd8;
   localparam logic [6:0] RR_BAND_LOW1  = 7'd11;
   localparam logic [6:0] RR_BAND_NORM  = 7'd20;
   localparam logic [6:0] RR_BAND_HIGH2 = 7'd24;
   localparam logic [6:0] RR_CRISIS_HI  = 7'd30;
   localparam logic [6:0] RR_CRISIS_LO  = 7'd6;
   localparam logic [6:0] RR_SHOCK_MIN  = 7'd24;

   localparam logic [3:0] SCORE_CRITICAL = 4'd7;
   localparam logic [3:0] SCORE_SHOCK    = 4'd5;
   localparam logic [3:0] SCORE_HIGH     = 4'd4;

   typedef struct packed {
      logic [12:0] heart_rate_q4;
      logic [10:0] oxygen_sat_q4;
      logic [12:0] rmssd_tenths;
      logic [9:0]  resp_rate_q4;
      logic [8:0]  signal_quality_q8;
   } req_type;

   typedef struct packed {
      status_type  status;
      level_type   triage_level;
      logic [3:0]  warning_score;
      logic [6:0]  alert_bits;
      logic [8:0]  rounded_heart_rate;
      logic [6:0]  rounded_oxygen_sat;
      logic [6:0]  rounded_resp_rate;
   } rsp_type;

   typedef struct packed {
      logic [8:0] heart_rate;
      logic [6:0] oxygen_sat;
      logic [6:0] resp_rate;
      logic       invalid;
      logic       noisy;
      logic       rmssd_low;
   } vitals_type;

   typedef struct packed {
      logic       crisis;
      logic [1:0] hr_band;
      logic [1:0] sp_band;
      logic [1:0] rr_band;
      logic       hypoxia;
      logic       tachycardia;
      logic       bradycardia;
      logic       tachypnea;
      logic       bradypnea;
      logic       hr_very_high;
      logic       shock_vital;
   } class_type;

endpackage

[hdl/early_warning_vitals_triage.sv]
// Early warning vitals triage: three-stage scoring pipeline, top level.
// Depends on ewvt_pkg, ewvt_classify and the assertion macro header.
// A sample accepted at a clock edge is registered in s1_vitals_ff, then in s2_vitals_ff and
// s2_class_ff, then in rsp_ff, from which its result beat is driven onto the ports.
// Throughput is one sample per cycle; busy is high only during reset.
// The result strobe is never held off, so the pipeline never stalls.
// Synchronous reset clears the stage valid bits and restores both limits.
`timescale 1ns / 1ps
`include "early_warning_vitals_triage_macros.svh"

module early_warning_vitals_triage (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ewvt_pkg::req_type req_sample,
   output logic              rsp_valid,
   output ewvt_pkg::rsp_type rsp_result,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [12:0]       csr_wdata
);

   logic                 accept;
   logic [12:0]          shock_limit_ff;
   logic [8:0]           quality_limit_ff;

   ewvt_pkg::vitals_type s1_vitals_in;
   ewvt_pkg::vitals_type s1_vitals_ff;
   logic                 s1_valid_ff;

   ewvt_pkg::class_type  s2_class_in;
   ewvt_pkg::class_type  s2_class_ff;
   ewvt_pkg::vitals_type s2_vitals_ff;
   logic                 s2_valid_ff;

   ewvt_pkg::rsp_type    rsp_in;
   ewvt_pkg::rsp_type    rsp_ff;
   logic                 rsp_valid_ff;

   logic [13:0]          hr_sum;
   logic [11:0]          sp_sum;
   logic [10:0]          rr_sum;
   logic [3:0]           score;
   logic                 shock;
   logic                 held;
   logic [6:0]           flags;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         shock_limit_ff   <= ewvt_pkg::SHOCK_RMSSD_RESET;
         quality_limit_ff <= ewvt_pkg::QUALITY_HOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ewvt_pkg::CSR_SHOCK_RMSSD_LIMIT: begin
               shock_limit_ff <= csr_wdata;
            end
            ewvt_pkg::CSR_QUALITY_HOLD_LIMIT: begin
               quality_limit_ff <= csr_wdata[8:0];
            end
            default: begin
               shock_limit_ff <= shock_limit_ff;
            end
         endcase
      end
   end

   always_comb begin
      hr_sum = {1'b0, req_sample.heart_rate_q4} + 14'd8;
      sp_sum = {1'b0, req_sample.oxygen_sat_q4} + 12'd8;
      rr_sum = {1'b0, req_sample.resp_rate_q4} + 11'd8;
      s1_vitals_in.heart_rate = hr_sum[12:4];
      s1_vitals_in.oxygen_sat = sp_sum[10:4];
      s1_vitals_in.resp_rate  = (req_sample.resp_rate_q4 == 10'd0) ? ewvt_pkg::RR_DEFAULT
                                                                   : rr_sum[10:4];
      s1_vitals_in.invalid = (req_sample.heart_rate_q4 == 13'd0)
                          || (req_sample.heart_rate_q4 > ewvt_pkg::HR_Q4_VALID_MAX)
                          || (req_sample.oxygen_sat_q4 == 11'd0)
                          || (req_sample.oxygen_sat_q4 > ewvt_pkg::SPO2_Q4_VALID_MAX);
      s1_vitals_in.noisy = (req_sample.signal_quality_q8 != 9'd0)
                        && (req_sample.signal_quality_q8 < quality_limit_ff);
      s1_vitals_in.rmssd_low = (req_sample.rmssd_tenths != 13'd0)
                            && (req_sample.rmssd_tenths <= ewvt_pkg::RMSSD_AVAIL_MAX)
                            && (req_sample.rmssd_tenths < shock_limit_ff);
   end

   ewvt_classify u_classify (
      .vitals (s1_vitals_ff),
      .result (s2_class_in)
   );

   always_comb begin
      score = {2'b00, s2_class_ff.hr_band} + {2'b00, s2_class_ff.sp_band}
            + {2'b00, s2_class_ff.rr_band};
      shock = s2_vitals_ff.rmssd_low && s2_class_ff.shock_vital;
      held  = s2_vitals_ff.noisy && !s2_class_ff.crisis;

      flags = '0;
      flags[ewvt_pkg::ALERT_LOW_SPO2]    = s2_class_ff.hypoxia;
      flags[ewvt_pkg::ALERT_FAST_HEART]  = s2_class_ff.tachycardia;
      flags[ewvt_pkg::ALERT_SLOW_HEART]  = s2_class_ff.bradycardia;
      flags[ewvt_pkg::ALERT_FAST_BREATH] = s2_class_ff.tachypnea;
      flags[ewvt_pkg::ALERT_SLOW_BREATH] = s2_class_ff.bradypnea;
      flags[ewvt_pkg::ALERT_SHOCK]       = shock;
      flags[ewvt_pkg::ALERT_NOISE]       = s2_vitals_ff.noisy;

      rsp_in.status             = ewvt_pkg::STATUS_ASSESSED;
      rsp_in.warning_score      = score;
      rsp_in.alert_bits         = flags;
      rsp_in.rounded_heart_rate = s2_vitals_ff.heart_rate;
      rsp_in.rounded_oxygen_sat = s2_vitals_ff.oxygen_sat;
      rsp_in.rounded_resp_rate  = s2_vitals_ff.resp_rate;

      priority if (s2_class_ff.crisis || (score >= ewvt_pkg::SCORE_CRITICAL)
                   || (shock && (score >= ewvt_pkg::SCORE_SHOCK))) begin
         rsp_in.triage_level = ewvt_pkg::LEVEL_CRITICAL;
      end else if ((score >= ewvt_pkg::SCORE_HIGH) || s2_class_ff.hypoxia
                   || s2_class_ff.hr_very_high || s2_class_ff.bradycardia
                   || s2_class_ff.tachypnea || shock) begin
         rsp_in.triage_level = ewvt_pkg::LEVEL_HIGH;
      end else if (score != 4'd0) begin
         rsp_in.triage_level = ewvt_pkg::LEVEL_ELEVATED;
      end else begin
         rsp_in.triage_level = ewvt_pkg::LEVEL_NORMAL;
      end

      priority if (s2_vitals_ff.invalid) begin
         rsp_in        = '0;
         rsp_in.status = ewvt_pkg::STATUS_INVALID;
      end else if (held) begin
         rsp_in.status        = ewvt_pkg::STATUS_HELD;
         rsp_in.triage_level  = ewvt_pkg::LEVEL_ELEVATED;
         rsp_in.warning_score = 4'd0;
         rsp_in.alert_bits    = '0;
         rsp_in.alert_bits[ewvt_pkg::ALERT_NOISE] = 1'b1;
      end else begin
         rsp_in.status = ewvt_pkg::STATUS_ASSESSED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_vitals_ff <= s1_vitals_in;
      s2_vitals_ff <= s1_vitals_ff;
      s2_class_ff  <= s2_class_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   `EWVT_ASSERT_IMPLY(a_beat_latency, clock, reset,
      !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3),
      rsp_valid == $past(accept, 3))
   `EWVT_ASSERT_IMPLY(a_invalid_zero, clock, reset,
      rsp_valid && (rsp_result.status == ewvt_pkg::STATUS_INVALID),
      (rsp_result.triage_level == ewvt_pkg::LEVEL_NORMAL) && (rsp_result.warning_score == 4'd0)
      && (rsp_result.alert_bits == 7'd0) && (rsp_result.rounded_heart_rate == 9'd0))
   `EWVT_ASSERT_IMPLY(a_held_shape, clock, reset,
      rsp_valid && (rsp_result.status == ewvt_pkg::STATUS_HELD),
      (rsp_result.triage_level == ewvt_pkg::LEVEL_ELEVATED)
      && (rsp_result.warning_score == 4'd0) && $onehot(rsp_result.alert_bits)
      && rsp_result.alert_bits[ewvt_pkg::ALERT_NOISE])
   `EWVT_ASSERT_IMPLY(a_normal_no_score, clock, reset,
      rsp_valid && (rsp_result.status == ewvt_pkg::STATUS_ASSESSED)
      && (rsp_result.triage_level == ewvt_pkg::LEVEL_NORMAL),
      rsp_result.warning_score == 4'd0)
   `EWVT_ASSERT(a_score_range, clock, reset,
      !rsp_valid || (rsp_result.warning_score <= 4'd9))

endmodule

[hdl/ewvt_classify.sv]
// Band scores, crisis test and alert conditions for one rounded vitals set.
// Depends on ewvt_pkg for the vitals and classification structs.
`timescale 1ns / 1ps

module ewvt_classify (
   input  ewvt_pkg::vitals_type vitals,
   output ewvt_pkg::class_type  result
);

   logic [8:0] hr;
   logic [6:0] sp;
   logic [6:0] rr;

   assign hr = vitals.heart_rate;
   assign sp = vitals.oxygen_sat;
   assign rr = vitals.resp_rate;

   always_comb begin
      result = '0;
      priority if (hr <= ewvt_pkg::HR_BAND_LOW3) begin
         result.hr_band = 2'd3;
      end else if (hr <= ewvt_pkg::HR_BAND_LOW1) begin
         result.hr_band = 2'd1;
      end else if (hr <= ewvt_pkg::HR_BAND_NORM) begin
         result.hr_band = 2'd0;
      end else if (hr <= ewvt_pkg::HR_BAND_HIGH1) begin
         result.hr_band = 2'd1;
      end else if (hr <= ewvt_pkg::HR_BAND_HIGH2) begin
         result.hr_band = 2'd2;
      end else begin
         result.hr_band = 2'd3;
      end

      priority if (sp >= ewvt_pkg::SP_BAND_NORM) begin
         result.sp_band = 2'd0;
      end else if (sp >= ewvt_pkg::SP_BAND_MILD) begin
         result.sp_band = 2'd1;
      end else if (sp >= ewvt_pkg::SP_BAND_MOD) begin
         result.sp_band = 2'd2;
      end else begin
         result.sp_band = 2'd3;
      end

      priority if (rr <= ewvt_pkg::RR_BAND_LOW3) begin
         result.rr_band = 2'd3;
      end else if (rr <= ewvt_pkg::RR_BAND_LOW1) begin
         result.rr_band = 2'd1;
      end else if (rr <= ewvt_pkg::RR_BAND_NORM) begin
         result.rr_band = 2'd0;
      end else if (rr <= ewvt_pkg::RR_BAND_HIGH2) begin
         result.rr_band = 2'd2;
      end else begin
         result.rr_band = 2'd3;
      end

      result.crisis = (sp <= ewvt_pkg::SP_CRISIS_MAX) || (hr >= ewvt_pkg::HR_CRISIS_HI)
                   || (hr <= ewvt_pkg::HR_CRISIS_LO) || (rr >= ewvt_pkg::RR_CRISIS_HI)
                   || (rr <= ewvt_pkg::RR_CRISIS_LO);
      result.hypoxia      = sp <= ewvt_pkg::SP_HYPOXIA_MAX;
      result.tachycardia  = hr > ewvt_pkg::HR_BAND_HIGH1;
      result.bradycardia  = hr <= ewvt_pkg::HR_BAND_LOW3;
      result.tachypnea    = rr > ewvt_pkg::RR_BAND_HIGH2;
      result.bradypnea    = rr <= ewvt_pkg::RR_BAND_LOW3;
      result.hr_very_high = hr > ewvt_pkg::HR_BAND_HIGH2;
      result.shock_vital  = (hr >= ewvt_pkg::HR_SHOCK_MIN) || (sp <= ewvt_pkg::SP_SHOCK_MAX)
                         || (rr >= ewvt_pkg::RR_SHOCK_MIN);
   end

endmodule

[tb/triage_score_checker.sv]
// Checker for the vitals triage block: tracks the limit registers, predicts each result beat
// from the accepted sample beats and compares it field by field in arrival order.
// Depends on ewvt_pkg for the beat types, status and level codes and register indexes.
`timescale 1ns / 1ps

module triage_score_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  ewvt_pkg::req_type req_sample,
   input  logic              rsp_valid,
   input  ewvt_pkg::rsp_type rsp_result,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [12:0]       csr_wdata,
   output int                errors,
   output int                pending
);
   import ewvt_pkg::*;

   logic [12:0] shock_limit;
   logic [8:0]  hold_limit;
   rsp_type     expected_triage[$];

   function automatic int unsigned heart_band(int unsigned hr);
      if (hr <= 40) return 3;
      if (hr <= 50) return 1;
      if (hr <= 90) return 0;
      if (hr <= 110) return 1;
      if (hr <= 130) return 2;
      return 3;
   endfunction

   function automatic int unsigned sat_band(int unsigned sp);
      if (sp >= 96) return 0;
      if (sp >= 94) return 1;
      if (sp >= 92) return 2;
      return 3;
   endfunction

   function automatic int unsigned breath_band(int unsigned rr);
      if (rr <= 8) return 3;
      if (rr <= 11) return 1;
      if (rr <= 20) return 0;
      if (rr <= 24) return 2;
      return 3;
   endfunction

   function automatic rsp_type predict_triage(req_type s);
      int unsigned hr, sp, rr, score;
      logic        crisis, noisy, shock;
      rsp_type     r;
      r = '0;
      if (s.heart_rate_q4 == 0 || s.heart_rate_q4 > 5599 ||
          s.oxygen_sat_q4 == 0 || s.oxygen_sat_q4 > 1600) begin
         r.status = STATUS_INVALID;
         return r;
      end
      hr = (int'(s.heart_rate_q4) + 8) >> 4;
      sp = (int'(s.oxygen_sat_q4) + 8) >> 4;
      rr = (s.resp_rate_q4 == 0) ? 14 : ((int'(s.resp_rate_q4) + 8) >> 4);
      r.rounded_heart_rate = 9'(hr);
      r.rounded_oxygen_sat = 7'(sp);
      r.rounded_resp_rate = 7'(rr);
      crisis = (sp <= 85) || (hr >= 150) || (hr <= 39) || (rr >= 30) || (rr <= 6);
      noisy = (s.signal_quality_q8 != 0) && (s.signal_quality_q8 < hold_limit);
      if (noisy && !crisis) begin
         r.status = STATUS_HELD;
         r.triage_level = LEVEL_ELEVATED;
         r.alert_bits[ALERT_NOISE] = 1'b1;
         return r;
      end
      score = heart_band(hr) + sat_band(sp) + breath_band(rr);
      shock = (s.rmssd_tenths != 0) && (s.rmssd_tenths <= 4999) &&
              (s.rmssd_tenths < shock_limit) && (hr >= 100 || sp <= 94 || rr >= 24);
      r.status = STATUS_ASSESSED;
      r.warning_score = 4'(score);
      r.alert_bits[ALERT_LOW_SPO2] = (sp <= 91);
      r.alert_bits[ALERT_FAST_HEART] = (hr >= 111);
      r.alert_bits[ALERT_SLOW_HEART] = (hr <= 40);
      r.alert_bits[ALERT_FAST_BREATH] = (rr >= 25);
      r.alert_bits[ALERT_SLOW_BREATH] = (rr <= 8);
      r.alert_bits[ALERT_SHOCK] = shock;
      r.alert_bits[ALERT_NOISE] = noisy;
      if (crisis || score >= 7 || (shock && score >= 5))
         r.triage_level = LEVEL_CRITICAL;
      else if (score >= 4 || sp <= 91 || hr >= 131 || hr <= 40 || rr >= 25 || shock)
         r.triage_level = LEVEL_HIGH;
      else if (score >= 1)
         r.triage_level = LEVEL_ELEVATED;
      else
         r.triage_level = LEVEL_NORMAL;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shock_limit = SHOCK_RMSSD_RESET;
         hold_limit = QUALITY_HOLD_RESET;
         expected_triage.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_triage.size() == 0) begin
               $error("result beat arrived with no sample beat outstanding");
               errors++;
            end else begin
               want = expected_triage.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_result.status));
               check_field("triage_level", 16'(want.triage_level),
                           16'(rsp_result.triage_level));
               check_field("warning_score", 16'(want.warning_score),
                           16'(rsp_result.warning_score));
               check_field("alert_bits", 16'(want.alert_bits), 16'(rsp_result.alert_bits));
               check_field("rounded_heart_rate", 16'(want.rounded_heart_rate),
                           16'(rsp_result.rounded_heart_rate));
               check_field("rounded_oxygen_sat", 16'(want.rounded_oxygen_sat),
                           16'(rsp_result.rounded_oxygen_sat));
               check_field("rounded_resp_rate", 16'(want.rounded_resp_rate),
                           16'(rsp_result.rounded_resp_rate));
            end
         end
         if (start && !busy)
            expected_triage.push_back(predict_triage(req_sample));
         if (csr_we) begin
            if (csr_index == CSR_SHOCK_RMSSD_LIMIT)
               shock_limit = csr_wdata;
            else
               hold_limit = csr_wdata[8:0];
         end
      end
      pending = expected_triage.size();
   end

endmodule

[tb/tb.sv]
// Top of the vitals triage testbench: clock, reset, sample and register stimulus, verdict.
// Instantiates early_warning_vitals_triage and triage_score_checker; uses ewvt_pkg types.
`timescale 1ns / 1ps

module tb;
   import ewvt_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_sample;
   logic        rsp_valid;
   rsp_type     rsp_result;
   logic        csr_we;
   logic        csr_index;
   logic [12:0] csr_wdata;
   int          errors;
   int          pending;

   early_warning_vitals_triage dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   triage_score_checker triage_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic req_type vitals(int hr, int sp, int rm, int rr, int sq);
      req_type s;
      s.heart_rate_q4 = 13'(hr);
      s.oxygen_sat_q4 = 11'(sp);
      s.rmssd_tenths = 13'(rm);
      s.resp_rate_q4 = 10'(rr);
      s.signal_quality_q8 = 9'(sq);
      return s;
   endfunction

   function automatic int near_q4(int lo, int hi, int top_q);
      int q;
      q = $urandom_range(lo, hi) * 16 + $urandom_range(0, 15) - 8;
      if (q > top_q) q = top_q;
      if (q < 1) q = 1;
      return q;
   endfunction

   function automatic req_type random_sample(int hold);
      req_type s;
      int      pick;
      int      lo;
      if ($urandom_range(0, 99) < 10) begin
         s = 56'({$urandom, $urandom});
         return s;
      end
      s.heart_rate_q4 = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(1, 5599))
                                                    : 13'(near_q4(30, 160, 5599));
      s.oxygen_sat_q4 = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(1, 1600))
                                                    : 11'(near_q4(82, 100, 1600));
      pick = $urandom_range(0, 99);
      if (pick < 15) s.resp_rate_q4 = 10'd0;
      else if (pick < 20) s.resp_rate_q4 = 10'($urandom_range(1, 1023));
      else s.resp_rate_q4 = 10'(near_q4(3, 34, 1023));
      pick = $urandom_range(0, 99);
      if (pick < 20) s.rmssd_tenths = 13'd0;
      else if (pick < 60) s.rmssd_tenths = 13'($urandom_range(1, 150));
      else if (pick < 80) s.rmssd_tenths = 13'($urandom_range(1, 4999));
      else s.rmssd_tenths = 13'($urandom_range(4990, 8191));
      pick = $urandom_range(0, 99);
      lo = (hold > 20) ? hold - 20 : 0;
      if (pick < 15) s.signal_quality_q8 = 9'd0;
      else if (pick < 65) s.signal_quality_q8 = 9'($urandom_range(lo, hold + 20));
      else s.signal_quality_q8 = 9'($urandom_range(0, 256));
      return s;
   endfunction

   task automatic send_sample(input req_type s, input bit may_idle);
      req_sample <= s;
      start <= 1'b1;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      if (may_idle) begin
         while ($urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 13'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input int shock, input int hold, input int count,
                            input bit no_idle, input int pause_at);
      write_csr(CSR_SHOCK_RMSSD_LIMIT, shock);
      write_csr(CSR_QUALITY_HOLD_LIMIT, hold);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) begin
            start <= 1'b0;
            wait_drained();
         end
         send_sample(random_sample(hold), !no_idle);
      end
      start <= 1'b0;
      wait_drained();
   endtask

   initial begin
      req_type directed[$];
      reset <= 1'b1;
      start <= 1'b0;
      req_sample <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_SHOCK_RMSSD_LIMIT;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Invalid vitals, extremes, rounding edges, crisis, hold, shock and default rate.
      directed.push_back(vitals(0, 1568, 500, 256, 0));
      directed.push_back(vitals(5600, 1568, 500, 256, 0));
      directed.push_back(vitals(8191, 2047, 8191, 1023, 511));
      directed.push_back(vitals(1120, 0, 500, 256, 0));
      directed.push_back(vitals(1120, 1601, 500, 256, 0));
      directed.push_back(vitals(5599, 1600, 4999, 1023, 256));
      directed.push_back(vitals(1, 1, 1, 1, 1));
      directed.push_back(vitals(1120, 1568, 500, 0, 0));
      directed.push_back(vitals(1120, 1568, 500, 256, 100));
      directed.push_back(vitals(2560, 1568, 500, 256, 100));
      directed.push_back(vitals(1680, 1552, 50, 256, 256));
      directed.push_back(vitals(1680, 1552, 5000, 256, 256));
      directed.push_back(vitals(1680, 1552, 0, 256, 256));
      directed.push_back(vitals(1120, 1568, 500, 256, 511));
      directed.push_back(vitals(1120, 1568, 500, 1, 0));
      directed.push_back(vitals(648, 1568, 500, 256, 0));
      directed.push_back(vitals(647, 1463, 500, 256, 0));
      directed.push_back(vitals(1120, 1464, 500, 400, 0));
      directed.push_back(vitals(1120, 1568, 500, 128, 0));
      directed.push_back(vitals(1120, 1568, 500, 480, 0));
      directed.push_back(vitals(1120, 1568, 500, 96, 0));
      directed.push_back(vitals(2160, 1488, 500, 352, 0));
      directed.push_back(vitals(1920, 1488, 10, 352, 0));
      directed.push_back(vitals(2096, 1360, 79, 240, 179));
      foreach (directed[i]) send_sample(directed[i], 1'b1);
      start <= 1'b0;
      wait_drained();

      run_phase(4999, 256, 275, 1'b0, -1);
      run_phase(0, 0, 275, 1'b0, -1);
      run_phase($urandom_range(0, 4999), $urandom_range(0, 256), 275, 1'b0, 120);
      run_phase(80, 180, 275, 1'b1, -1);
      run_phase($urandom_range(0, 4999), $urandom_range(0, 256), 275, 1'b0, -1);
      run_phase(2500, 200, 275, 1'b0, -1);

      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/ewvt_pkg.sv
hdl/ewvt_classify.sv
hdl/early_warning_vitals_triage.sv
tb/triage_score_checker.sv
tb/tb.sv
